// ----- hdl/rn12_pkg.sv -----
package rn12_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int MAX_STRIDE = 16384;

    localparam int CNT_W    = $clog2(MAX_WIDTH) + 1;
    localparam int HEIGHT_W = $clog2(MAX_HEIGHT) + 1;
    localparam int STRIDE_W = $clog2(MAX_STRIDE) + 1;
    localparam int ADDR_W   = 27;
    localparam int PROD_W   = HEIGHT_W + STRIDE_W;
    localparam int PIX_W    = 32;
    localparam int CFG_W    = STRIDE_W;
    localparam int CFG_IDX_W = 2;

    localparam int IN_W  = 4 * PIX_W;
    localparam int OUT_FIELDS_W = 3 * 16 + 3 * ADDR_W;
    localparam int OUT_W = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_STRIDE   = 2'd2;

    localparam logic [CNT_W-1:0]    RESET_WIDTH  = 13'd640;
    localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 13'd480;
    localparam logic [STRIDE_W-1:0] RESET_STRIDE = 15'd640;

    // BT.601 studio range coefficients
    localparam int LUMA_R = 66;
    localparam int LUMA_G = 129;
    localparam int LUMA_B = 25;
    localparam int ROUND  = 128;
    localparam int LUMA_OFS = 16;
    localparam int CB_R = 38;
    localparam int CB_G = 74;
    localparam int CB_B = 112;
    localparam int CR_R = 112;
    localparam int CR_G = 94;
    localparam int CR_B = 18;
    localparam int CHROMA_BIAS = ROUND + (128 << 8);

    typedef struct packed {
        logic [CNT_W-1:0]    width;
        logic [HEIGHT_W-1:0] height;
        logic [STRIDE_W-1:0] stride;
    } cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] y_top;
        logic [ADDR_W-1:0] y_bottom;
        logic [ADDR_W-1:0] uv;
        logic [CNT_W-1:0]  col;
        logic              last;
    } addr_t;

endpackage

// ----- hdl/rn12_lane.sv -----
module rn12_lane
    import rn12_pkg::*;
(
    input  logic             aclk,
    input  logic             en,
    input  logic [PIX_W-1:0] pixel,
    output logic [7:0]       luma
);

    logic [7:0]  r_reg, g_reg, b_reg;
    logic [7:0]  luma_reg;
    logic [15:0] sum;

    always_comb begin
        sum = 16'(LUMA_R * r_reg) + 16'(LUMA_G * g_reg) + 16'(LUMA_B * b_reg) + 16'(ROUND);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg    <= pixel[23:16];
            g_reg    <= pixel[15:8];
            b_reg    <= pixel[7:0];
            luma_reg <= sum[15:8] + 8'(LUMA_OFS);
        end
    end

    assign luma = luma_reg;

endmodule

// ----- hdl/rn12_chroma.sv -----
module rn12_chroma
    import rn12_pkg::*;
(
    input  logic             aclk,
    input  logic             en,
    input  logic [PIX_W-1:0] pixel,
    output logic [15:0]      uv
);

    logic [7:0]  r_reg, g_reg, b_reg;
    logic [15:0] uv_reg;
    logic [16:0] u_sum, v_sum;

    // bias keeps both sums non-negative, so bits 15:8 are the floored byte
    always_comb begin
        u_sum = 17'(CB_B * b_reg) + 17'(CHROMA_BIAS) - 17'(CB_R * r_reg) - 17'(CB_G * g_reg);
        v_sum = 17'(CR_R * r_reg) + 17'(CHROMA_BIAS) - 17'(CR_G * g_reg) - 17'(CR_B * b_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg  <= pixel[23:16];
            g_reg  <= pixel[15:8];
            b_reg  <= pixel[7:0];
            uv_reg <= {v_sum[15:8], u_sum[15:8]};
        end
    end

    assign uv = uv_reg;

endmodule

// ----- hdl/rn12_addr.sv -----
module rn12_addr
    import rn12_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  cfg_t  cfg,
    input  logic  cfg_clear,
    input  logic  accept,
    input  logic  en,
    output logic  empty,
    output addr_t addr
);

    logic [CNT_W-1:0]    col_reg, col_next;
    logic [HEIGHT_W-1:0] row_reg, row_next;
    logic [CNT_W-1:0]    col_s1_reg;
    logic [HEIGHT_W-1:0] row_s1_reg;
    logic                last_s1_reg;
    addr_t               addr_reg;
    logic                row_end, last_row;
    logic [PROD_W-1:0]   p_top, p_bot, p_uv;

    always_comb begin
        empty    = (cfg.height < HEIGHT_W'(2)) || (cfg.width == '0);
        row_end  = ({1'b0, col_reg} + (CNT_W+1)'(2)) >= {1'b0, cfg.width};
        last_row = ({1'b0, row_reg} + (HEIGHT_W+1)'(3)) >= {1'b0, cfg.height};
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_clear || (accept && empty)) begin
            col_next = '0;
            row_next = '0;
        end else if (accept) begin
            if (row_end) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + HEIGHT_W'(2);
            end else begin
                col_next = col_reg + CNT_W'(2);
            end
        end
    end

    always_comb begin
        p_top = PROD_W'(row_s1_reg) * PROD_W'(cfg.stride);
        p_bot = (PROD_W'(row_s1_reg) + PROD_W'(1)) * PROD_W'(cfg.stride);
        p_uv  = (PROD_W'(row_s1_reg >> 1) + PROD_W'(cfg.height)) * PROD_W'(cfg.stride);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            col_s1_reg     <= col_reg;
            row_s1_reg     <= row_reg;
            last_s1_reg    <= row_end && last_row;
            addr_reg.y_top    <= p_top[ADDR_W-1:0];
            addr_reg.y_bottom <= p_bot[ADDR_W-1:0];
            addr_reg.uv       <= p_uv[ADDR_W-1:0];
            addr_reg.col      <= col_s1_reg;
            addr_reg.last     <= last_s1_reg;
        end
    end

    assign addr = addr_reg;

endmodule

// ----- hdl/rgb32_to_nv12_converter.sv -----
// channel  dir  tdata                                   tlast       width
// s_       in   tl, tr, bl, br pixels (32 each)         -           128
// m_       out  y_top, y_bot, uv, 3 addresses           frame_last  136
//
// One item per cycle sustained unless m_tready stalls the output; valid passes v1, v2 and the output register.
// Stages: input capture, constant-coefficient lanes and stride multiply, address add.
// Synchronous active-low reset clears control and counters and loads the default configuration.
// The whole pipe advances when the output register is empty or being taken.
// Items accepted with an empty frame (height < 2 or width 0) give no output.
module rgb32_to_nv12_converter
    import rn12_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_W-1:0]      s_tdata,   // top_left, top_right, bottom_left, bottom_right
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_W-1:0]     m_tdata,   // y_top_pair, y_bottom_pair, uv_pair,
                                            // y_top_addr, y_bottom_addr, uv_addr, zero pad
    output logic                 m_tlast,   // frame_last
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    cfg_t             cfg_reg;
    logic             v1_reg, v2_reg, out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic             out_last_reg;
    logic             en, accept, empty, cfg_clear;
    logic [7:0]       y_tl, y_tr, y_bl, y_br;
    logic [15:0]      uv;
    addr_t            addr;
    logic [ADDR_W-1:0] a_top, a_bot, a_uv;

    assign en        = !out_valid_reg || m_tready;
    assign s_tready  = en;
    assign accept    = s_tvalid && en;
    assign cfg_clear = cfg_we && (cfg_addr == CFG_FRAME_WIDTH || cfg_addr == CFG_FRAME_HEIGHT
                                  || cfg_addr == CFG_OUT_STRIDE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.width  <= RESET_WIDTH;
            cfg_reg.height <= RESET_HEIGHT;
            cfg_reg.stride <= RESET_STRIDE;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_FRAME_WIDTH:  cfg_reg.width  <= cfg_wdata[CNT_W-1:0];
                CFG_FRAME_HEIGHT: cfg_reg.height <= cfg_wdata[HEIGHT_W-1:0];
                CFG_OUT_STRIDE:   cfg_reg.stride <= cfg_wdata[STRIDE_W-1:0];
                default: ;
            endcase
        end
    end

    rn12_lane u_lane_tl (.aclk(aclk), .en(en), .pixel(s_tdata[PIX_W-1:0]),         .luma(y_tl));
    rn12_lane u_lane_tr (.aclk(aclk), .en(en), .pixel(s_tdata[2*PIX_W-1:PIX_W]),   .luma(y_tr));
    rn12_lane u_lane_bl (.aclk(aclk), .en(en), .pixel(s_tdata[3*PIX_W-1:2*PIX_W]), .luma(y_bl));
    rn12_lane u_lane_br (.aclk(aclk), .en(en), .pixel(s_tdata[4*PIX_W-1:3*PIX_W]), .luma(y_br));

    rn12_chroma u_chroma (
        .aclk  (aclk),
        .en    (en),
        .pixel (s_tdata[3*PIX_W-1:2*PIX_W]),
        .uv    (uv)
    );

    rn12_addr u_addr (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cfg_clear (cfg_clear),
        .accept    (accept),
        .en        (en),
        .empty     (empty),
        .addr      (addr)
    );

    // merge: add column offset and pack
    always_comb begin
        a_top = addr.y_top    + ADDR_W'(addr.col);
        a_bot = addr.y_bottom + ADDR_W'(addr.col);
        a_uv  = addr.uv       + ADDR_W'(addr.col);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg        <= accept && !empty;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= OUT_W'({a_uv, a_bot, a_top, uv, y_br, y_bl, y_tr, y_tl});
            out_last_reg <= addr.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- hdl/rn12_checker.sv -----
module rn12_checker
    import rn12_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [OUT_W-1:0]     m_tdata,
    input logic                 m_tlast
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output item dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output item changed while stalled");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output space");

    a_luma_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:0] >= 8'd16 && m_tdata[7:0] <= 8'd235
                  && m_tdata[23:16] >= 8'd16 && m_tdata[23:16] <= 8'd235)
        else $error("luma outside studio range");

endmodule

bind rgb32_to_nv12_converter rn12_checker u_rn12_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
